// ===== rtl/mpp_pkg.sv =====
// Package with the constants, widths and control types of the modular power block.
`timescale 1ns / 1ps

package mpp_pkg;

    localparam int EXP_BITS = 30;
    localparam int FIELD_W  = 30;
    localparam int EXP_W    = (EXP_BITS > FIELD_W) ? EXP_BITS : FIELD_W;
    localparam int CNT_W    = $clog2(EXP_W);

    localparam logic [FIELD_W-1:0] MOD_P   = FIELD_W'(1000000007);
    localparam logic [EXP_W-1:0]   INV_EXP = EXP_W'(1000000005);
    localparam logic [EXP_W-1:0]   EXP_MASK =
        EXP_W'((64'd1 << EXP_BITS) - 64'd1);

    // Barrett constant floor(2^60 / P), which fits in 31 bits.
    localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] MU      = MU_FULL[30:0];

    localparam int MM_STAGES = 6;

    localparam logic REQ_POWER   = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic sel_sq;
        logic acc_wr;
        logic exp_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mm_done;
        logic exp_msb;
    } sts_t;

endpackage

// ===== rtl/mpp_mulmod.sv =====
// Pipelined Barrett modular multiplier for the prime modulus.
`timescale 1ns / 1ps

module mpp_mulmod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mpp_pkg::FIELD_W-1:0] op_a,
    input  logic [mpp_pkg::FIELD_W-1:0] op_b,
    output logic                        done,
    output logic [mpp_pkg::FIELD_W-1:0] res
);

    logic [mpp_pkg::MM_STAGES-1:0] vld_reg;
    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] lo_a_reg;
    logic [31:0] lo_b_reg;
    logic [31:0] q3p_reg;
    logic [31:0] r_reg;
    logic [31:0] r1_reg;
    logic [mpp_pkg::FIELD_W-1:0] res_reg;

    logic [60:0] q3p_full;
    logic [31:0] r1_next;
    logic [31:0] r2_next;

    assign q3p_full = q2_reg[61:31] * mpp_pkg::MOD_P;
    assign r1_next  = (r_reg >= 32'(mpp_pkg::MOD_P)) ? r_reg - 32'(mpp_pkg::MOD_P) : r_reg;
    assign r2_next  = (r1_reg >= 32'(mpp_pkg::MOD_P)) ? r1_reg - 32'(mpp_pkg::MOD_P) : r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[mpp_pkg::MM_STAGES-2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        q2_reg   <= prod_reg[59:29] * mpp_pkg::MU;
        lo_a_reg <= prod_reg[31:0];
        q3p_reg  <= q3p_full[31:0];
        lo_b_reg <= lo_a_reg;
        r_reg    <= lo_b_reg - q3p_reg;
        r1_reg   <= r1_next;
        res_reg  <= r2_next[mpp_pkg::FIELD_W-1:0];
    end

    assign done = vld_reg[mpp_pkg::MM_STAGES-1];
    assign res  = res_reg;

endmodule

// ===== rtl/mpp_datapath.sv =====
// Datapath with the accumulator, base, exponent and result registers.
`timescale 1ns / 1ps

module mpp_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mpp_pkg::cmd_t               cmd,
    output mpp_pkg::sts_t               sts,
    input  logic                        s_req_type,
    input  logic [mpp_pkg::FIELD_W-1:0] s_base,
    input  logic [mpp_pkg::FIELD_W-1:0] s_exponent,
    output logic [mpp_pkg::FIELD_W-1:0] m_result
);

    logic [mpp_pkg::FIELD_W-1:0] acc_reg;
    logic [mpp_pkg::FIELD_W-1:0] base_reg;
    logic [mpp_pkg::EXP_W-1:0]   exp_reg;
    logic [mpp_pkg::FIELD_W-1:0] result_reg;

    logic [mpp_pkg::FIELD_W-1:0] op_b;
    logic [mpp_pkg::FIELD_W-1:0] mm_res;
    logic                        mm_done;
    logic [mpp_pkg::EXP_W-1:0]   exp_in;

    assign op_b   = cmd.sel_sq ? acc_reg : base_reg;
    assign exp_in = (s_req_type == mpp_pkg::REQ_INVERSE) ? mpp_pkg::INV_EXP
                  : (mpp_pkg::EXP_W'(s_exponent) & mpp_pkg::EXP_MASK);

    mpp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .op_a    (acc_reg),
        .op_b    (op_b),
        .done    (mm_done),
        .res     (mm_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg  <= mpp_pkg::FIELD_W'(1);
            base_reg <= (s_base >= mpp_pkg::MOD_P) ? s_base - mpp_pkg::MOD_P : s_base;
            exp_reg  <= exp_in;
        end else begin
            if (cmd.acc_wr) begin
                acc_reg <= mm_res;
            end
            if (cmd.exp_shift) begin
                exp_reg <= {exp_reg[mpp_pkg::EXP_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            result_reg <= acc_reg;
        end
    end

    assign sts.mm_done = mm_done;
    assign sts.exp_msb = exp_reg[mpp_pkg::EXP_W-1];
    assign m_result    = result_reg;

endmodule

// ===== rtl/mpp_ctrl.sv =====
// Controller state machine that sequences square-and-multiply over the exponent bits.
`timescale 1ns / 1ps

module mpp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  mpp_pkg::sts_t sts,
    output mpp_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SQ_ISSUE  = 7'b0000010,
        ST_SQ_WAIT   = 7'b0000100,
        ST_MUL_ISSUE = 7'b0001000,
        ST_MUL_WAIT  = 7'b0010000,
        ST_ADVANCE   = 7'b0100000,
        ST_OUT       = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [mpp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = mpp_pkg::CNT_W'(mpp_pkg::EXP_W - 1);
                    state_next = ST_SQ_ISSUE;
                end
            end
            ST_SQ_ISSUE: begin
                cmd.start  = 1'b1;
                cmd.sel_sq = 1'b1;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sts.mm_done) begin
                    cmd.acc_wr = 1'b1;
                    state_next = sts.exp_msb ? ST_MUL_ISSUE : ST_ADVANCE;
                end
            end
            ST_MUL_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (sts.mm_done) begin
                    cmd.acc_wr = 1'b1;
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.exp_shift = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    state_next    = ST_SQ_ISSUE;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/modular_power_prime.sv =====
// Top level of the modular power and inverse block over the prime 1000000007.
// The input channel (s_valid, s_ready) takes one request word: s_req_type selects a
// power with s_exponent (0) or a Fermat inverse (1), and s_base is the base.
// The result channel (m_valid, m_ready) returns one word per request on m_result.
// Requests are handled one at a time by square-and-multiply from the top exponent bit.
// Each exponent bit takes a squaring and, when the bit is one, a multiplication,
// both done by the six-stage modular multiplier that the two steps share.
// All 30 exponent bits are walked for every request; an inverse has a fixed exponent.
// s_ready is high only while the block is free, so the next request can be taken in the
// cycle after the previous result has been moved to the output register.
// A finished result waits in the output register while the receiver stalls; the
// block may accept and compute the next request meanwhile, and holds that one
// until the output register is free.
// Reset returns the controller to idle and empties the output register.
`timescale 1ns / 1ps

module modular_power_prime (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [mpp_pkg::FIELD_W-1:0] s_base,
    input  logic [mpp_pkg::FIELD_W-1:0] s_exponent,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mpp_pkg::FIELD_W-1:0] m_result
);

    mpp_pkg::cmd_t cmd;
    mpp_pkg::sts_t sts;

    mpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mpp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_req_type (s_req_type),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .m_result   (m_result)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Block accepted a word while still busy.");

    a_done_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.mm_done |-> !s_ready)
        else $error("Multiplier finished while the controller was idle.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("Output register overwritten before its word was taken.");

    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result < mpp_pkg::MOD_P))
        else $error("Result is not reduced below the modulus.");

endmodule
